// ===== rtl/nmr_pkg.sv =====
// shared types and widths for the normal-map renormalizer pipeline
// no dependencies; used by nmr_step and normal_map_renormalize
`default_nettype none

package nmr_pkg;

    localparam int NUM_STAGES  = 9;   // front, sum/square, one per root bit
    localparam int SEARCH_BITS = 7;   // root magnitude 0..127
    localparam int S_W         = 18;  // sum of three odd squares, max 195075
    localparam int T_W         = 32;  // (255 m)^2, max 4228250625
    localparam int A_W         = 34;  // 4 k^2 S, max about 1.26e10
    localparam int B_W         = 28;  // 8 k S, max about 1.98e8

    // one color channel in flight through the root search
    typedef struct packed {
        logic                   neg;  // component below the midpoint
        logic [SEARCH_BITS-1:0] k;    // root bits found so far
        logic [A_W-1:0]         a;    // 4 k^2 S
        logic [B_W-1:0]         b;    // 8 k S
        logic [T_W-1:0]         t;    // 65025 m^2
    } t_lane;

    // one texel in flight
    typedef struct packed {
        t_lane [2:0]    lane;  // red, green, blue
        logic [S_W-1:0] s;
        logic [7:0]     alpha;
        logic           last;
    } t_texel;

endpackage

`default_nettype wire

// ===== rtl/nmr_step.sv =====
// one bit of the restoring root search for all three channels of a texel
// depends on nmr_pkg
`default_nettype none

module nmr_step
    import nmr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_load,
    input  wire logic [2:0]   i_bit,
    input  wire t_texel       i_texel,
    output t_texel            o_texel
);

    t_texel               n_texel;
    t_texel               r_texel;
    logic [A_W-1:0]       w_trial [3];
    logic                 w_take  [3];

    // trial 4 (k + d)^2 S with d = 2^bit, built from shifts of the running sums
    always_comb begin
        n_texel = i_texel;
        for (int l = 0; l < 3; l++) begin
            w_trial[l] = i_texel.lane[l].a
                       + (A_W'(i_texel.lane[l].b) << i_bit)
                       + (A_W'(i_texel.s) << ({1'b0, i_bit, 1'b0} + 5'd2));
            // below midpoint wants strictly less, above wants less or equal
            w_take[l]  = i_texel.lane[l].neg ?
                         (w_trial[l] <  A_W'(i_texel.lane[l].t)) :
                         (w_trial[l] <= A_W'(i_texel.lane[l].t));
            if (w_take[l]) begin
                n_texel.lane[l].k = i_texel.lane[l].k | (SEARCH_BITS'(1) << i_bit);
                n_texel.lane[l].a = w_trial[l];
                n_texel.lane[l].b = i_texel.lane[l].b
                                  + (B_W'(i_texel.s) << ({1'b0, i_bit} + 4'd3));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_texel <= n_texel;
        end
    end

    assign o_texel = r_texel;

endmodule

`default_nettype wire

// ===== rtl/normal_map_renormalize.sv =====
// top level of the rgb8 normal-map renormalizer: stream ports and pipeline
// depends on nmr_pkg and nmr_step
`default_nettype none

// Renormalizes one RGB8 normal-map texel per word. Each color byte c is read as
// the odd value v = 2c - 255; the output byte is 127.5 + 127.5 * v / |v_vec|,
// rounded half up, computed exactly in integer arithmetic by a square-root
// style search for the largest k with 4 k^2 S <= 65025 v^2 (strict for negative
// v), giving 128 + k or 127 - k. Alpha and tlast pass through untouched.
// Throughput is one texel per clock while the output is not stalled. In order,
// one stage forms |v|, v^2 and 255|v|, one stage forms the sum S
// and the 16x16 square, then seven stages each settle one bit of k with
// shift-add updates. Every stage has its own valid bit and loads whenever it is
// empty or its successor moves, so bubbles close up and a stall at the output
// holds everything without loss. The block has no state between texels.
module normal_map_renormalize
    import nmr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // alpha[7:0], red[15:8], green[23:16], blue[31:24]
    input  wire logic        i_s_tlast,   // last texel of the surface
    // output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // alpha[7:0], red[15:8], green[23:16], blue[31:24]
    output logic             o_m_tlast    // last texel of the surface
);

    // front stage contents
    typedef struct packed {
        logic [2:0]        neg;
        logic [2:0][15:0]  sq;   // m^2
        logic [2:0][15:0]  w;    // 255 m
        logic [7:0]        alpha;
        logic              last;
    } t_front;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] w_rdy;

    t_front                r_front;
    t_front                n_front;
    t_texel                r_mid;
    t_texel                n_mid;
    t_texel                w_chain [SEARCH_BITS+1];
    logic [7:0]            w_c     [3];
    logic [7:0]            w_m     [3];
    logic [7:0]            w_out   [3];

    // ready ripples back from the output; a stage moves if empty or drained
    always_comb begin
        w_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
    end

    assign o_s_tready = w_rdy[0];

    // valid bits follow the data
    always_comb begin
        n_vld = r_vld;
        if (w_rdy[0]) begin
            n_vld[0] = i_s_tvalid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (w_rdy[i]) begin
                n_vld[i] = r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 1: magnitude |2c - 255|, its square and 255 times it
    assign w_c[0] = i_s_tdata[15:8];
    assign w_c[1] = i_s_tdata[23:16];
    assign w_c[2] = i_s_tdata[31:24];

    always_comb begin
        n_front.alpha = i_s_tdata[7:0];
        n_front.last  = i_s_tlast;
        for (int l = 0; l < 3; l++) begin
            // upper half: 2c - 255; lower half: 255 - 2c
            w_m[l]        = w_c[l][7] ? {w_c[l][6:0], 1'b1} : ~{w_c[l][6:0], 1'b0};
            n_front.neg[l] = !w_c[l][7];
            n_front.sq[l]  = 16'(w_m[l]) * 16'(w_m[l]);
            n_front.w[l]   = {w_m[l], 8'h00} - 16'(w_m[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_front <= n_front;
        end
    end

    // stage 2: sum of squares and target 65025 m^2, search state cleared
    always_comb begin
        n_mid.alpha = r_front.alpha;
        n_mid.last  = r_front.last;
        n_mid.s     = S_W'(r_front.sq[0]) + S_W'(r_front.sq[1]) + S_W'(r_front.sq[2]);
        for (int l = 0; l < 3; l++) begin
            n_mid.lane[l].neg = r_front.neg[l];
            n_mid.lane[l].k   = '0;
            n_mid.lane[l].a   = '0;
            n_mid.lane[l].b   = '0;
            n_mid.lane[l].t   = T_W'(r_front.w[l]) * T_W'(r_front.w[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_mid <= n_mid;
        end
    end

    assign w_chain[0] = r_mid;

    // stages 3..9: one root bit each, most significant first
    for (genvar g = 0; g < SEARCH_BITS; g++) begin : g_search
        nmr_step u_step (
            .i_clk   (i_clk),
            .i_load  (w_rdy[g+2]),
            .i_bit   (3'(SEARCH_BITS - 1 - g)),
            .i_texel (w_chain[g]),
            .o_texel (w_chain[g+1])
        );
    end

    // re-encode: 128 + k above the midpoint, 127 - k below
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_out[l] = w_chain[SEARCH_BITS].lane[l].neg ?
                       {1'b0, ~w_chain[SEARCH_BITS].lane[l].k} :
                       {1'b1,  w_chain[SEARCH_BITS].lane[l].k};
        end
    end

    assign o_m_tvalid = r_vld[NUM_STAGES-1];
    assign o_m_tdata  = {w_out[2], w_out[1], w_out[0], w_chain[SEARCH_BITS].alpha};
    assign o_m_tlast  = w_chain[SEARCH_BITS].last;

endmodule

`default_nettype wire
